[hw/rtl/pcm_pkg.sv]
`default_nettype none
package pcm_pkg;

	typedef enum logic [2:0] {
		OP_SET_OFFSET = 3'd0,
		OP_LINK       = 3'd1,
		OP_SET_COUNT  = 3'd2,
		OP_STATE_FACT = 3'd3,
		OP_FETCH      = 3'd4
	} op_code_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_LINK_FULL = 2'd1,
		STAT_FACT_OOR  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ROUND,
		ST_WRAP,
		ST_OFF,
		ST_FID,
		ST_HRD,
		ST_HEAD,
		ST_WALK,
		ST_LINK,
		ST_OPRD,
		ST_SCAN,
		ST_SCHK,
		ST_RESP
	} state_t;

endpackage
`default_nettype wire

[hw/rtl/pcm_ram.sv]
`default_nettype none
// Simple dual-port RAM, registered read, no reset on contents.
module pcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                     wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                     rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[hw/rtl/precondition_count_match.sv]
`default_nettype none
// Channel  | handshake               | payload
// input    | in_valid / in_stall     | op, var_index, fact_value, operator_index,
//          |                         | needed_count, first_fact
// output   | out_valid / out_stall   | applicable_op, found, status
// config   | cfg_wen                 | cfg_wdata (operator_count)
//
// Per item: op 1 links the operator onto the fact's list and op 3 walks every
// link on that list, both stopping early on a bad fact id; op 4 scans operators
// from the cursor until one is applicable or the scan runs out. A stamp wrap
// first clears every round stamp.
// After reset a clearing pass clears list heads, precondition totals and round
// stamps; in_stall is high meanwhile.
// One item is in work at a time. A finished result sits in the output register
// while the next item is taken; a stalled output only holds back a second one.
module precondition_count_match #(
	parameter int MAX_VARIABLES     = 64,
	parameter int MAX_FACTS         = 1024,
	parameter int MAX_OPERATORS     = 1024,
	parameter int MAX_LINKS         = 8192,
	parameter int MAX_PRECONDITIONS = 16,
	parameter int STAMP_BITS        = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic [10:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  op,
	input  wire logic [5:0]  var_index,
	input  wire logic [9:0]  fact_value,
	input  wire logic [9:0]  operator_index,
	input  wire logic [4:0]  needed_count,
	input  wire logic        first_fact,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [9:0]       applicable_op,
	output logic             found,
	output logic [1:0]       status
);
	localparam int VA_W  = MAX_VARIABLES > 1 ? $clog2(MAX_VARIABLES) : 1;
	localparam int FA_W  = $clog2(MAX_FACTS);
	localparam int OA_W  = MAX_OPERATORS > 1 ? $clog2(MAX_OPERATORS) : 1;
	localparam int LA_W  = MAX_LINKS > 1 ? $clog2(MAX_LINKS) : 1;
	localparam int HW    = $clog2(MAX_LINKS + 1);   // head = link number + 1
	localparam int PW    = $clog2(MAX_PRECONDITIONS + 1);
	localparam int CUR_W = $clog2(MAX_OPERATORS + 1);
	localparam int CLR_N = MAX_FACTS > MAX_OPERATORS ? MAX_FACTS : MAX_OPERATORS;
	localparam int CLR_W = $clog2(CLR_N + 1);

	pcm_pkg::state_t state_q, state_d;

	// control registers
	logic [CLR_W-1:0]      idx_q;
	logic [STAMP_BITS-1:0] round_q;
	logic [HW-1:0]         lu_q;
	logic [CUR_W-1:0]      cursor_q;
	logic [10:0]           opcount_q;
	logic                  out_valid_q;

	// item and work registers
	logic [2:0]       op_q;
	logic [5:0]       var_q;
	logic [9:0]       val_q;
	logic [9:0]       opi_q;
	logic [4:0]       need_q;
	logic             first_q;
	logic [FA_W-1:0]  fid_q;
	logic [HW-1:0]    p_q;
	logic [OA_W-1:0]  o_q;
	logic [CUR_W-1:0] sidx_q;
	logic [9:0]       res_op_q;
	logic             res_found_q;
	logic [1:0]       res_status_q;
	logic [9:0]       applicable_op_q;
	logic             found_q;
	logic [1:0]       status_q;

	// memory ports
	logic              vo_we;
	logic [9:0]        vo_rdata;
	logic              fh_we;
	logic [FA_W-1:0]   fh_waddr;
	logic [HW-1:0]     fh_wdata, fh_rdata;
	logic              lk_we;
	logic [9:0]        lo_rdata;
	logic [HW-1:0]     ln_rdata;
	logic              pt_we;
	logic [OA_W-1:0]   pt_waddr, op_raddr;
	logic [PW-1:0]     pt_wdata, pt_rdata;
	logic              rc_we;
	logic [PW-1:0]     rc_wdata, rc_rdata;
	logic              rs_we;
	logic [OA_W-1:0]   rs_waddr;
	logic [STAMP_BITS-1:0] rs_wdata, rs_rdata;

	// datapath helpers
	logic                  accept;
	logic                  out_load;
	logic [16:0]           fid_sum;
	logic                  var_ok, fid_ok, opi_ok;
	logic [STAMP_BITS-1:0] round_inc;
	logic                  round_start;
	logic [16:0]           scan_limit;
	logic [PW-1:0]         cnt_eff;
	logic                  scan_hit;
	logic [PW-1:0]         need_sat;

	assign accept      = in_valid && (state_q == pcm_pkg::ST_IDLE);
	assign in_stall    = (state_q != pcm_pkg::ST_IDLE);
	assign fid_sum     = 17'(vo_rdata) + 17'(val_q);
	assign var_ok      = 32'(var_q) < MAX_VARIABLES;
	assign fid_ok      = var_ok && (fid_sum < 17'(MAX_FACTS));
	assign opi_ok      = 17'(opi_q) < 17'(MAX_OPERATORS);
	assign round_inc   = round_q + 1'b1;
	assign round_start = first_q || (round_q == '0);
	assign scan_limit  = (17'(opcount_q) < 17'(MAX_OPERATORS)) ? 17'(opcount_q)
	                                                           : 17'(MAX_OPERATORS);
	// reload the count when the stamp is from an older round
	assign cnt_eff     = (rs_rdata != round_q) ? pt_rdata : rc_rdata;
	assign scan_hit    = (pt_rdata == '0) ||
	                     ((round_q != '0) && (rs_rdata == round_q) && (rc_rdata == '0));
	assign need_sat    = (8'(need_q) > 8'(MAX_PRECONDITIONS)) ? PW'(MAX_PRECONDITIONS)
	                                                          : PW'(need_q);
	assign out_load    = (state_q == pcm_pkg::ST_RESP) && (!out_valid_q || !out_stall);

	// next state and memory controls
	always_comb begin
		state_d  = state_q;
		vo_we    = 1'b0;
		fh_we    = 1'b0;
		fh_waddr = fid_q;
		fh_wdata = HW'(lu_q + 1'b1);
		lk_we    = 1'b0;
		pt_we    = 1'b0;
		pt_waddr = OA_W'(opi_q);
		pt_wdata = need_sat;
		rc_we    = 1'b0;
		rc_wdata = (cnt_eff == '0) ? '0 : PW'(cnt_eff - 1'b1);
		rs_we    = 1'b0;
		rs_waddr = o_q;
		rs_wdata = round_q;
		op_raddr = (state_q == pcm_pkg::ST_SCAN) ? OA_W'(cursor_q) : OA_W'(lo_rdata);
		case (state_q)
			pcm_pkg::ST_CLEAR: begin
				fh_we    = 32'(idx_q) < MAX_FACTS;
				fh_waddr = FA_W'(idx_q);
				fh_wdata = '0;
				pt_we    = 32'(idx_q) < MAX_OPERATORS;
				pt_waddr = OA_W'(idx_q);
				pt_wdata = '0;
				rs_we    = pt_we;
				rs_waddr = OA_W'(idx_q);
				rs_wdata = '0;
				if (idx_q == CLR_W'(CLR_N - 1)) begin
					state_d = pcm_pkg::ST_IDLE;
				end
			end
			pcm_pkg::ST_IDLE: begin
				if (accept) begin
					case (op)
						pcm_pkg::OP_STATE_FACT: state_d = pcm_pkg::ST_ROUND;
						pcm_pkg::OP_LINK:       state_d = pcm_pkg::ST_OFF;
						pcm_pkg::OP_FETCH:      state_d = pcm_pkg::ST_SCAN;
						default:                state_d = pcm_pkg::ST_RESP;
					endcase
				end
			end
			pcm_pkg::ST_ROUND: begin
				state_d = (round_start && round_inc == '0) ? pcm_pkg::ST_WRAP
				                                           : pcm_pkg::ST_OFF;
			end
			pcm_pkg::ST_WRAP: begin
				rs_we    = 1'b1;
				rs_waddr = OA_W'(idx_q);
				rs_wdata = '0;
				if (idx_q == CLR_W'(MAX_OPERATORS - 1)) begin
					state_d = pcm_pkg::ST_OFF;
				end
			end
			pcm_pkg::ST_OFF: state_d = pcm_pkg::ST_FID;
			pcm_pkg::ST_FID: state_d = fid_ok ? pcm_pkg::ST_HRD : pcm_pkg::ST_RESP;
			pcm_pkg::ST_HRD: state_d = pcm_pkg::ST_HEAD;
			pcm_pkg::ST_HEAD: begin
				if (op_q == pcm_pkg::OP_LINK) begin
					if (opi_ok && (lu_q < HW'(MAX_LINKS))) begin
						lk_we = 1'b1;
						fh_we = 1'b1;
					end
					state_d = pcm_pkg::ST_RESP;
				end else begin
					state_d = pcm_pkg::ST_WALK;
				end
			end
			pcm_pkg::ST_WALK: state_d = (p_q == '0) ? pcm_pkg::ST_RESP : pcm_pkg::ST_LINK;
			pcm_pkg::ST_LINK: state_d = pcm_pkg::ST_OPRD;
			pcm_pkg::ST_OPRD: begin
				rc_we   = 1'b1;
				rs_we   = 1'b1;
				state_d = pcm_pkg::ST_WALK;
			end
			pcm_pkg::ST_SCAN: begin
				state_d = (17'(cursor_q) < scan_limit) ? pcm_pkg::ST_SCHK
				                                        : pcm_pkg::ST_RESP;
			end
			pcm_pkg::ST_SCHK: state_d = scan_hit ? pcm_pkg::ST_RESP : pcm_pkg::ST_SCAN;
			pcm_pkg::ST_RESP: begin
				vo_we = (op_q == pcm_pkg::OP_SET_OFFSET) && var_ok;
				pt_we = (op_q == pcm_pkg::OP_SET_COUNT) && opi_ok;
				if (out_load) begin
					state_d = pcm_pkg::ST_IDLE;
				end
			end
			default: state_d = pcm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcm_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			round_q     <= '0;
			lu_q        <= '0;
			cursor_q    <= '0;
			opcount_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				opcount_q <= cfg_wdata;
			end
			if (state_q == pcm_pkg::ST_CLEAR || state_q == pcm_pkg::ST_WRAP) begin
				idx_q <= idx_q + 1'b1;
			end else begin
				idx_q <= '0;
			end
			if (state_q == pcm_pkg::ST_ROUND && round_start) begin
				round_q  <= (round_inc == '0) ? STAMP_BITS'(1) : round_inc;
				cursor_q <= '0;
			end
			if (lk_we) begin
				lu_q <= lu_q + 1'b1;
			end
			if (state_q == pcm_pkg::ST_SCAN && state_d == pcm_pkg::ST_SCHK) begin
				cursor_q <= cursor_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= op;
			var_q        <= var_index;
			val_q        <= fact_value;
			opi_q        <= operator_index;
			need_q       <= needed_count;
			first_q      <= first_fact;
			res_op_q     <= '0;
			res_found_q  <= 1'b0;
			res_status_q <= pcm_pkg::STAT_OK;
		end
		if (state_q == pcm_pkg::ST_FID) begin
			fid_q <= FA_W'(fid_sum);
			if (!fid_ok) begin
				res_status_q <= pcm_pkg::STAT_FACT_OOR;
			end
		end
		if (state_q == pcm_pkg::ST_HEAD) begin
			p_q <= fh_rdata;
			if (op_q == pcm_pkg::OP_LINK && opi_ok && !(lu_q < HW'(MAX_LINKS))) begin
				res_status_q <= pcm_pkg::STAT_LINK_FULL;
			end
		end
		if (state_q == pcm_pkg::ST_LINK) begin
			o_q <= OA_W'(lo_rdata);
			p_q <= ln_rdata;
		end
		if (state_q == pcm_pkg::ST_SCAN) begin
			sidx_q <= cursor_q;
		end
		if (state_q == pcm_pkg::ST_SCHK && scan_hit) begin
			res_op_q    <= 10'(sidx_q);
			res_found_q <= 1'b1;
		end
		if (out_load) begin
			applicable_op_q <= res_op_q;
			found_q         <= res_found_q;
			status_q        <= res_status_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign applicable_op = applicable_op_q;
	assign found         = found_q;
	assign status        = status_q;

	pcm_ram #(.WIDTH(10), .DEPTH(MAX_VARIABLES)) u_var_offset (
		.clk   (clk),
		.we    (vo_we),
		.waddr (VA_W'(var_q)),
		.wdata (val_q),
		.raddr (VA_W'(var_q)),
		.rdata (vo_rdata)
	);

	pcm_ram #(.WIDTH(HW), .DEPTH(MAX_FACTS)) u_fact_head (
		.clk   (clk),
		.we    (fh_we),
		.waddr (fh_waddr),
		.wdata (fh_wdata),
		.raddr (fid_q),
		.rdata (fh_rdata)
	);

	pcm_ram #(.WIDTH(10), .DEPTH(MAX_LINKS)) u_link_operator (
		.clk   (clk),
		.we    (lk_we),
		.waddr (LA_W'(lu_q)),
		.wdata (opi_q),
		.raddr (LA_W'(p_q - 1'b1)),
		.rdata (lo_rdata)
	);

	pcm_ram #(.WIDTH(HW), .DEPTH(MAX_LINKS)) u_link_next (
		.clk   (clk),
		.we    (lk_we),
		.waddr (LA_W'(lu_q)),
		.wdata (fh_rdata),
		.raddr (LA_W'(p_q - 1'b1)),
		.rdata (ln_rdata)
	);

	pcm_ram #(.WIDTH(PW), .DEPTH(MAX_OPERATORS)) u_precondition_total (
		.clk   (clk),
		.we    (pt_we),
		.waddr (pt_waddr),
		.wdata (pt_wdata),
		.raddr (op_raddr),
		.rdata (pt_rdata)
	);

	pcm_ram #(.WIDTH(PW), .DEPTH(MAX_OPERATORS)) u_remaining_count (
		.clk   (clk),
		.we    (rc_we),
		.waddr (o_q),
		.wdata (rc_wdata),
		.raddr (op_raddr),
		.rdata (rc_rdata)
	);

	pcm_ram #(.WIDTH(STAMP_BITS), .DEPTH(MAX_OPERATORS)) u_round_stamp (
		.clk   (clk),
		.we    (rs_we),
		.waddr (rs_waddr),
		.wdata (rs_wdata),
		.raddr (op_raddr),
		.rdata (rs_rdata)
	);
endmodule
`default_nettype wire

[hw/rtl/pcm_checker.sv]
`default_nettype none
module pcm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [9:0] applicable_op,
	input wire logic       found,
	input wire logic [1:0] status
);
	// a held result keeps its operator index and found flag
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(applicable_op) && $stable(found))
		else $error("stalled result changed");

	// a found operator never comes with an error status
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> status == pcm_pkg::STAT_OK)
		else $error("found with error status");

	// operator index is zero unless an operator was found
	a_op_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> applicable_op == 10'd0)
		else $error("operator index without found");

	// status code three is never produced
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == pcm_pkg::STAT_OK || status == pcm_pkg::STAT_LINK_FULL ||
			status == pcm_pkg::STAT_FACT_OOR)
		else $error("bad status code");
endmodule

bind precondition_count_match pcm_checker u_pcm_checker (.*);
`default_nettype wire

[tb/sv/pcm_checker.sv]
`default_nettype none
module pcm_scoreboard (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic [10:0] cfg_wdata,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [2:0]  op,
	input  wire logic [5:0]  var_index,
	input  wire logic [9:0]  fact_value,
	input  wire logic [9:0]  operator_index,
	input  wire logic [4:0]  needed_count,
	input  wire logic        first_fact,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [9:0]  applicable_op,
	input  wire logic        found,
	input  wire logic [1:0]  status,
	output int               errors,
	output int               pending
);
	localparam int NVAR = 64;
	localparam int NFACT = 1024;
	localparam int NOPER = 1024;
	localparam int NLINK = 8192;
	localparam int NPRE = 16;

	typedef struct packed {
		logic [9:0] aop;
		logic       fnd;
		logic [1:0] st;
	} match_t;

	match_t     match_q[$];
	logic [10:0] oper_limit;
	logic [9:0]  offset_tab[NVAR];
	logic [13:0] head_tab[NFACT];
	logic [9:0]  link_oper[NLINK];
	logic [13:0] link_nxt[NLINK];
	logic [13:0] link_cnt;
	logic [4:0]  pre_total[NOPER];
	logic [4:0]  remain[NOPER];
	logic [15:0] stamp[NOPER];
	logic [15:0] round_no;
	logic [10:0] cursor;

	function automatic void start_round();
		round_no = round_no + 16'd1;
		if (round_no == 16'd0) begin
			foreach (stamp[i]) stamp[i] = '0;
			round_no = 16'd1;
		end
		cursor = '0;
	endfunction

	function automatic match_t predict_match(logic [2:0] c, logic [5:0] v, logic [9:0] val,
		logic [9:0] oi, logic [4:0] need, logic first);
		match_t r;
		logic [10:0] fid;
		logic [13:0] p;
		logic [9:0] o;
		int lim;
		r = '0;
		fid = {1'b0, offset_tab[v]} + {1'b0, val};
		case (c)
			pcm_pkg::OP_SET_OFFSET: offset_tab[v] = val;
			pcm_pkg::OP_LINK: begin
				if (fid >= NFACT) r.st = pcm_pkg::STAT_FACT_OOR;
				else if (link_cnt >= NLINK) r.st = pcm_pkg::STAT_LINK_FULL;
				else begin
					link_oper[link_cnt] = oi;
					link_nxt[link_cnt] = head_tab[fid];
					link_cnt = link_cnt + 14'd1;
					head_tab[fid] = link_cnt;
				end
			end
			pcm_pkg::OP_SET_COUNT: pre_total[oi] = (need > NPRE) ? 5'(NPRE) : need;
			pcm_pkg::OP_STATE_FACT: begin
				if (first || round_no == 0) start_round();
				if (fid >= NFACT) r.st = pcm_pkg::STAT_FACT_OOR;
				else begin
					p = head_tab[fid];
					while (p != 0) begin
						o = link_oper[p - 14'd1];
						if (stamp[o] != round_no) begin
							remain[o] = pre_total[o];
							stamp[o] = round_no;
						end
						if (remain[o] != 0) remain[o] = remain[o] - 5'd1;
						p = link_nxt[p - 14'd1];
					end
				end
			end
			pcm_pkg::OP_FETCH: begin
				lim = (oper_limit < NOPER) ? oper_limit : NOPER;
				while (cursor < lim && !r.fnd) begin
					if (pre_total[cursor] == 0 || (round_no != 0 &&
						stamp[cursor] == round_no && remain[cursor] == 0)) begin
						r.aop = cursor[9:0];
						r.fnd = 1'b1;
					end
					cursor = cursor + 11'd1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		match_t got, want, nxt;
		if (!arst_n) begin
			match_q.delete();
			oper_limit = '0;
			foreach (offset_tab[i]) offset_tab[i] = '0;
			foreach (head_tab[i]) head_tab[i] = '0;
			foreach (pre_total[i]) pre_total[i] = '0;
			foreach (stamp[i]) stamp[i] = '0;
			foreach (remain[i]) remain[i] = '0;
			link_cnt = '0;
			round_no = '0;
			cursor = '0;
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_wen) oper_limit = cfg_wdata;
			if (out_valid && !out_stall) begin
				got = '{applicable_op, found, status};
				if (match_q.size() == 0) begin
					$error("result transfer with nothing expected");
					errors++;
				end else begin
					want = match_q.pop_front();
					if (got.aop !== want.aop) begin
						$error("applicable_op expected %0d got %0d", want.aop, got.aop);
						errors++;
					end
					if (got.fnd !== want.fnd) begin
						$error("found expected %0d got %0d", want.fnd, got.fnd);
						errors++;
					end
					if (got.st !== want.st) begin
						$error("status expected %0d got %0d", want.st, got.st);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				nxt = predict_match(op, var_index, fact_value,
					operator_index, needed_count, first_fact);
				match_q = {match_q, nxt};
			end
			pending = match_q.size();
		end
	end
endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`default_nettype none
module testbench;
	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	logic [10:0] cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  op;
	logic [5:0]  var_index;
	logic [9:0]  fact_value;
	logic [9:0]  operator_index;
	logic [4:0]  needed_count;
	logic        first_fact;
	logic        out_valid;
	logic        out_stall;
	logic [9:0]  applicable_op;
	logic        found;
	logic [1:0]  status;
	int          errors;
	int          pending;

	// quiet: no idling on either side (last part of the run)
	// hold_out: request for one long output hold-off
	bit quiet;
	bit hold_out;

	precondition_count_match i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .var_index(var_index), .fact_value(fact_value),
		.operator_index(operator_index), .needed_count(needed_count),
		.first_fact(first_fact),
		.out_valid(out_valid), .out_stall(out_stall),
		.applicable_op(applicable_op), .found(found), .status(status)
	);

	pcm_scoreboard i_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .var_index(var_index), .fact_value(fact_value),
		.operator_index(operator_index), .needed_count(needed_count),
		.first_fact(first_fact),
		.out_valid(out_valid), .out_stall(out_stall),
		.applicable_op(applicable_op), .found(found), .status(status),
		.errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Hard stop, far beyond a run where every fetch scans all operators under stalls.
	initial begin
		#200000000;
		$display("testbench failed");
		$finish;
	end

	// Output side: random stall bursts, plus one long hold-off on request so the
	// block backs up and raises in_stall while the input side keeps offering items.
	initial begin
		bit held;
		held = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_out && !held) begin
				held = 1'b1;
				out_stall = 1'b1;
				repeat (300) @(negedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	// One input transfer. Payload is held until accepted; optional idle burst first.
	task automatic send(logic [2:0] c, logic [5:0] v, logic [9:0] val, logic [9:0] oi,
		logic [4:0] need, logic first);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		op = c;
		var_index = v;
		fact_value = val;
		operator_index = oi;
		needed_count = need;
		first_fact = first;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_limit(logic [10:0] n);
		in_valid = 1'b0;
		cfg_wen = 1'b1;
		cfg_wdata = n;
		@(negedge clk);
		cfg_wen = 1'b0;
	endtask

	// Wait until every expected result has come back, then let the bench settle.
	task automatic drain();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// A state: first fact opens the round, more facts follow, then a few fetches.
	// Variables 0..7 and small values keep the facts on the populated lists.
	task automatic state_burst();
		int k;
		k = $urandom_range(0, 5);
		send(pcm_pkg::OP_STATE_FACT, 6'($urandom_range(0, 7)), 10'($urandom_range(0, 15)),
			10'($urandom), 5'($urandom), 1'b1);
		repeat (k)
			send(pcm_pkg::OP_STATE_FACT, 6'($urandom_range(0, 7)),
				10'($urandom_range(0, 15)), 10'($urandom), 5'($urandom), 1'b0);
		repeat ($urandom_range(1, 6))
			send(pcm_pkg::OP_FETCH, 6'($urandom), 10'($urandom), 10'($urandom),
				5'($urandom), 1'($urandom));
	endtask

	initial begin
		logic [10:0] limits[5];
		int sent;
		int sel;
		quiet = 1'b0;
		hold_out = 1'b0;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		op = '0;
		var_index = '0;
		fact_value = '0;
		operator_index = '0;
		needed_count = '0;
		first_fact = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		write_limit(11'd8);
		// Offsets: every variable gets one, so no fact id comes from an unset entry.
		// Variable 63 sits near the top of the fact range.
		for (int v = 0; v < 63; v++)
			send(pcm_pkg::OP_SET_OFFSET, 6'(v), 10'(v * 16), '0, '0, 1'b0);
		send(pcm_pkg::OP_SET_OFFSET, 6'd63, 10'd1000, '0, '0, 1'b0);

		// Directed part.
		send(pcm_pkg::OP_FETCH, '0, '0, '0, '0, 1'b0);               // before any state
		send(pcm_pkg::OP_SET_COUNT, '0, '0, 10'd1, 5'd1, 1'b0);
		send(pcm_pkg::OP_SET_COUNT, '0, '0, 10'd2, 5'd16, 1'b0);
		send(pcm_pkg::OP_SET_COUNT, '0, '0, 10'd3, 5'd31, 1'b0);     // saturates
		send(pcm_pkg::OP_SET_COUNT, '0, '0, 10'd1023, 5'd0, 1'b0);
		send(pcm_pkg::OP_LINK, 6'd0, 10'd0, 10'd1, '0, 1'b0);
		send(pcm_pkg::OP_LINK, 6'd0, 10'd0, 10'd1, '0, 1'b0);        // count would go under zero; it stops at zero
		send(pcm_pkg::OP_LINK, 6'd0, 10'd1, 10'd2, '0, 1'b0);
		send(pcm_pkg::OP_LINK, 6'd63, 10'd1023, 10'd5, '0, 1'b0);    // fact id out of range
		send(pcm_pkg::OP_STATE_FACT, 6'd0, 10'd0, '0, '0, 1'b0);     // no flag, round still 0
		send(pcm_pkg::OP_STATE_FACT, 6'd63, 10'd1023, '0, '0, 1'b0); // fact id out of range
		repeat (8) send(pcm_pkg::OP_FETCH, '0, '0, '0, '0, 1'b0);    // runs past the end
		send(3'd5, 6'h3f, 10'h3ff, 10'h3ff, 5'h1f, 1'b1);
		send(3'd6, '0, '0, '0, '0, 1'b0);
		send(3'd7, 6'h2a, 10'h155, 10'h2aa, 5'h15, 1'b0);
		drain();

		// Random phases, one per operator_count setting, extremes included.
		limits = '{11'd0, 11'd1024, 11'd2047, 11'd1, 11'($urandom_range(2, 100))};
		foreach (limits[ph]) begin
			write_limit(limits[ph]);
			sent = 0;
			while (sent < 40) begin
				if (ph == 1 && sent == 20) hold_out = 1'b1;
				sel = $urandom_range(0, 99);
				if (sel < 65) begin
					state_burst();
				end else if (sel < 75) begin
					send(pcm_pkg::OP_LINK, 6'($urandom_range(0, 7)),
						10'($urandom_range(0, 15)), 10'($urandom_range(0, 63)),
						5'($urandom), 1'($urandom));
				end else if (sel < 85) begin
					send(pcm_pkg::OP_SET_COUNT, 6'($urandom), 10'($urandom),
						10'($urandom_range(0, 63)), 5'($urandom_range(0, 5)), 1'($urandom));
				end else begin
					// noise over the whole field ranges and unused codes
					send(3'($urandom), 6'($urandom), 10'($urandom), 10'($urandom),
						5'($urandom), 1'($urandom));
				end
				sent++;
			end
			drain();
		end

		// Last part, no idling: restore variable 63, then a few more states.
		quiet = 1'b1;
		write_limit(11'd64);
		send(pcm_pkg::OP_SET_OFFSET, 6'd63, 10'd1000, '0, '0, 1'b0);
		send(pcm_pkg::OP_STATE_FACT, 6'd63, 10'd0, '0, '0, 1'b1);
		send(pcm_pkg::OP_FETCH, '0, '0, '0, '0, 1'b0);
		repeat (4) state_burst();
		drain();
		repeat (40) @(negedge clk);

		if (errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end
endmodule
`default_nettype wire

[precondition_count_match.f]
hw/rtl/pcm_pkg.sv
hw/rtl/pcm_ram.sv
hw/rtl/precondition_count_match.sv
hw/rtl/pcm_checker.sv
tb/sv/pcm_checker.sv
tb/sv/testbench.sv
